FILE: sv/mtep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared constants, parse phases, note table records and result types.
// ----------------------------------------------------------------------------
package mtep_pkg;

	localparam int TICK_W      = 32;
	localparam int VL_W        = 28;
	localparam int SUM_W       = ((TICK_W > VL_W) ? TICK_W : VL_W) + 1;
	localparam int TRACK_LIMIT = 256;
	localparam int TRACK_W     = 8;
	localparam logic [TRACK_W-1:0] TRACK_MAX = TRACK_W'(TRACK_LIMIT - 1);

	localparam int NOTE_DEPTH = 2048;
	localparam int NOTE_AW    = $clog2(NOTE_DEPTH);
	localparam int EPOCH_W    = 14;

	localparam logic [7:0] ST_NONE    = 8'h00;
	localparam logic [7:0] ST_SYSEX   = 8'hF0;
	localparam logic [7:0] SYSEX_END  = 8'hF7;
	localparam logic [7:0] ST_SKIP    = 8'hFC;
	localparam logic [7:0] ST_META    = 8'hFF;
	localparam logic [7:0] META_TEMPO = 8'h51;
	localparam logic [3:0] SYS_NIBBLE = 4'hF;
	localparam logic [VL_W-1:0] TEMPO_LEN = VL_W'(3);

	localparam logic [3:0] MSG_OFF   = 4'h8;
	localparam logic [3:0] MSG_ON    = 4'h9;
	localparam logic [3:0] MSG_CTRL  = 4'hB;
	localparam logic [3:0] MSG_PROG  = 4'hC;
	localparam logic [3:0] MSG_PRESS = 4'hD;
	localparam logic [3:0] MSG_BEND  = 4'hE;

	typedef enum logic [3:0] {
		PH_DELTA,
		PH_STATUS,
		PH_DATA1,
		PH_DATA2,
		PH_META_TYPE,
		PH_META_LEN,
		PH_META_BODY,
		PH_SYSEX,
		PH_SKIP1
	} phase_t;

	typedef enum logic [2:0] {
		KIND_NOTE  = 3'd0,
		KIND_CTRL  = 3'd1,
		KIND_BEND  = 3'd2,
		KIND_PROG  = 3'd3,
		KIND_TEMPO = 3'd4,
		KIND_PRESS = 3'd5
	} kind_t;

	typedef struct packed {
		logic        sounding;
		logic [6:0]  velocity;
		logic [31:0] start;
	} note_rec_t;

	typedef struct packed {
		note_rec_t          rec;
		logic [EPOCH_W-1:0] tag;
	} note_ent_t;

	typedef struct packed {
		logic               lookup;
		logic [NOTE_AW-1:0] look_addr;
		logic               wr;
		logic [NOTE_AW-1:0] wr_addr;
		note_rec_t          wr_rec;
		logic               new_track;
	} tbl_req_t;

	typedef struct packed {
		kind_t              kind;
		logic [3:0]         channel;
		logic [6:0]         key_or_number;
		logic [13:0]        value;
		logic [31:0]        start_tick;
		logic [31:0]        event_tick;
		logic [23:0]        tempo_usec;
		logic [TRACK_W-1:0] track_number;
	} res_t;

endpackage
`default_nettype wire

FILE: sv/mtep_note_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI track event parser note table
// 16 x 128 note slots with epoch tags; clearing pass after reset and a
// background scrub that retires slots of earlier tracks.
// ----------------------------------------------------------------------------
module mtep_note_table import mtep_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire tbl_req_t  req,
	output note_rec_t      rd_rec,
	output logic           busy
);

	note_ent_t mem_q [NOTE_DEPTH];
	note_ent_t look_q;
	note_ent_t scr_q;

	logic               init_q;
	logic [NOTE_AW-1:0] sp_q;
	logic               sph_q;
	logic               hit_q;
	logic [EPOCH_W-1:0] epoch_q;

	logic               wr_en;
	logic [NOTE_AW-1:0] wr_addr;
	note_ent_t          wr_data;
	logic               scr_rd;
	logic               scr_wr;

	assign busy   = init_q;
	assign scr_rd = !init_q && !sph_q;
	assign scr_wr = !init_q && sph_q && scr_q.rec.sounding && (scr_q.tag != epoch_q)
		&& !hit_q && !req.wr;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sp_q;
		wr_data = '{rec: '0, tag: epoch_q};
		priority if (req.wr) begin
			wr_en   = 1'b1;
			wr_addr = req.wr_addr;
			wr_data = '{rec: req.wr_rec, tag: epoch_q};
		end else if (init_q || scr_wr) begin
			wr_en = 1'b1;
		end
	end

	always_comb begin
		rd_rec          = look_q.rec;
		rd_rec.sounding = look_q.rec.sounding && (look_q.tag == epoch_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (req.lookup) begin
			look_q <= mem_q[req.look_addr];
		end
		if (scr_rd) begin
			scr_q <= mem_q[sp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= 1'b1;
			sp_q    <= '0;
			sph_q   <= 1'b0;
			hit_q   <= 1'b0;
			epoch_q <= '0;
		end else begin
			if (req.new_track) begin
				epoch_q <= epoch_q + 1'b1;
			end
			if (init_q) begin
				sp_q  <= sp_q + 1'b1;
				sph_q <= 1'b0;
				if (sp_q == NOTE_AW'(NOTE_DEPTH - 1)) begin
					init_q <= 1'b0;
				end
			end else if (!sph_q) begin
				sph_q <= 1'b1;
				hit_q <= req.wr && (req.wr_addr == sp_q);
			end else begin
				sph_q <= 1'b0;
				if (!req.wr) begin
					sp_q <= sp_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/mtep_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI track event parser byte decoder
// Input register, parse state and the single-pass decode of one byte into
// at most one result and one note table access.
// ----------------------------------------------------------------------------
module mtep_parser import mtep_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       track_start,
	input  wire logic       busy,
	input  wire logic       out_free,
	input  wire note_rec_t  rd_rec,
	output tbl_req_t        req,
	output logic            res_vld,
	output res_t            res
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               tstart_s1;

	phase_t             phase_q;
	logic [7:0]         rs_q;
	logic [TICK_W-1:0]  tick_q;
	logic [VL_W-1:0]    vl_q;
	logic [6:0]         first_q;
	logic [7:0]         mkind_q;
	logic [VL_W-1:0]    mleft_q;
	logic [23:0]        tempo_q;
	logic [TRACK_W-1:0] tcount_q;
	logic               opened_q;

	phase_t             e_phase, n_phase;
	logic [7:0]         e_rs, n_rs;
	logic [TICK_W-1:0]  e_tick, n_tick;
	logic [VL_W-1:0]    e_vl, n_vl;
	logic [6:0]         e_first, n_first;
	logic [7:0]         e_mkind, n_mkind;
	logic [VL_W-1:0]    e_mleft, n_mleft;
	logic [23:0]        e_tempo, n_tempo;
	logic [TRACK_W-1:0] e_tcount;

	logic [7:0]         b;
	logic               fresh;
	logic [7:0]         st;
	logic               st_chan;
	logic               st_one;
	logic               rs_one;
	logic [VL_W-1:0]    vl_shift;
	logic [SUM_W-1:0]   dl_sum;
	logic [TICK_W-1:0]  dl_tick;
	logic [23:0]        tempo_new;
	logic [VL_W-1:0]    mleft_dec;

	logic               do_chan;
	logic               look;
	logic               tempo_emit;
	logic [6:0]         cd1;
	logic [6:0]         cd2;
	logic [3:0]         mtype;
	logic [3:0]         ch;
	logic               note_start;
	logic               note_end;
	logic               emit;
	logic               s1_go;

	assign b         = byte_s1;
	assign fresh     = b[7];
	assign st        = fresh ? b : e_rs;
	assign st_chan   = st[7] && (st[7:4] != SYS_NIBBLE);
	assign st_one    = (st[7:4] == MSG_PROG) || (st[7:4] == MSG_PRESS);
	assign rs_one    = (e_rs[7:4] == MSG_PROG) || (e_rs[7:4] == MSG_PRESS);
	assign vl_shift  = {e_vl[VL_W-8:0], b[6:0]};
	assign dl_sum    = SUM_W'(e_tick) + SUM_W'(vl_shift);
	assign dl_tick   = (dl_sum[SUM_W-1:TICK_W] != '0) ? '1 : dl_sum[TICK_W-1:0];
	assign tempo_new = {e_tempo[15:0], b};
	assign mleft_dec = e_mleft - 1'b1;
	assign mtype     = e_rs[7:4];
	assign ch        = e_rs[3:0];

	assign s1_go    = valid_s1 && (!emit || out_free);
	assign in_stall = busy || (valid_s1 && !s1_go);
	assign res_vld  = valid_s1 && emit;

	// clear parse state ahead of the first byte of a track
	always_comb begin
		e_phase  = tstart_s1 ? PH_DELTA : phase_q;
		e_rs     = tstart_s1 ? '0 : rs_q;
		e_tick   = tstart_s1 ? '0 : tick_q;
		e_vl     = tstart_s1 ? '0 : vl_q;
		e_first  = tstart_s1 ? '0 : first_q;
		e_mkind  = tstart_s1 ? '0 : mkind_q;
		e_mleft  = tstart_s1 ? '0 : mleft_q;
		e_tempo  = tstart_s1 ? '0 : tempo_q;
		e_tcount = tcount_q;
		if (tstart_s1 && opened_q && (tcount_q < TRACK_MAX)) begin
			e_tcount = tcount_q + 1'b1;
		end
	end

	// next state
	always_comb begin
		n_phase    = e_phase;
		n_rs       = e_rs;
		n_tick     = e_tick;
		n_vl       = e_vl;
		n_first    = e_first;
		n_mkind    = e_mkind;
		n_mleft    = e_mleft;
		n_tempo    = e_tempo;
		do_chan    = 1'b0;
		look       = 1'b0;
		tempo_emit = 1'b0;
		cd1        = b[6:0];
		cd2        = '0;
		unique case (e_phase)
			PH_STATUS: begin
				if (fresh) begin
					n_rs = b;
				end
				priority if (st == ST_META) begin
					if (fresh) begin
						n_phase = PH_META_TYPE;
					end else begin
						n_mkind = b;
						n_vl    = '0;
						n_phase = PH_META_LEN;
					end
				end else if (st == ST_SKIP) begin
					n_phase = fresh ? PH_SKIP1 : PH_DELTA;
				end else if (st == ST_NONE) begin
					n_phase = PH_DELTA;
				end else if (st == ST_SYSEX) begin
					n_phase = PH_SYSEX;
				end else if (st_chan) begin
					if (fresh) begin
						n_phase = PH_DATA1;
					end else if (st_one) begin
						do_chan = 1'b1;
					end else begin
						n_first = b[6:0];
						n_phase = PH_DATA2;
						look    = 1'b1;
					end
				end else begin
					n_phase = PH_DELTA;
					if (!fresh) begin
						n_tick  = dl_tick;
						n_vl    = '0;
						n_phase = PH_STATUS;
					end
				end
			end
			PH_DATA1: begin
				if (rs_one) begin
					do_chan = 1'b1;
				end else begin
					n_first = b[6:0];
					n_phase = PH_DATA2;
					look    = 1'b1;
				end
			end
			PH_DATA2: begin
				do_chan = 1'b1;
				cd1     = e_first;
				cd2     = b[6:0];
			end
			PH_META_TYPE: begin
				n_mkind = b;
				n_vl    = '0;
				n_phase = PH_META_LEN;
			end
			PH_META_LEN: begin
				n_vl = vl_shift;
				if (!b[7]) begin
					n_mleft = vl_shift;
					n_vl    = '0;
					n_tempo = '0;
					if (vl_shift != TEMPO_LEN) begin
						n_mkind = '0;
					end
					n_phase = (vl_shift == '0) ? PH_DELTA : PH_META_BODY;
				end
			end
			PH_META_BODY: begin
				n_tempo = tempo_new;
				n_mleft = mleft_dec;
				if (mleft_dec == '0) begin
					n_phase    = PH_DELTA;
					tempo_emit = (e_mkind == META_TEMPO);
				end
			end
			PH_SYSEX: begin
				if (b == SYSEX_END) begin
					n_phase = PH_DELTA;
				end
			end
			PH_SKIP1: begin
				n_phase = PH_DELTA;
			end
			default: begin
				n_phase = PH_DELTA;
				if (!b[7]) begin
					n_tick  = dl_tick;
					n_vl    = '0;
					n_phase = PH_STATUS;
				end else begin
					n_vl = vl_shift;
				end
			end
		endcase
		if (do_chan) begin
			n_phase = PH_DELTA;
		end
	end

	// result and note table access
	always_comb begin
		note_start = do_chan && (mtype == MSG_ON) && (cd2 != '0);
		note_end   = do_chan && ((mtype == MSG_OFF) || ((mtype == MSG_ON) && (cd2 == '0)));
		emit       = 1'b0;

		res               = '0;
		res.kind          = KIND_NOTE;
		res.channel       = ch;
		res.event_tick    = 32'(e_tick);
		res.track_number  = e_tcount;

		if (tempo_emit) begin
			emit           = 1'b1;
			res.kind       = KIND_TEMPO;
			res.channel    = '0;
			res.tempo_usec = tempo_new;
		end else if (do_chan) begin
			unique case (mtype)
				MSG_OFF, MSG_ON: begin
					if (note_end && rd_rec.sounding) begin
						emit              = 1'b1;
						res.key_or_number = cd1;
						res.value         = 14'(rd_rec.velocity);
						res.start_tick    = rd_rec.start;
					end
				end
				MSG_CTRL: begin
					emit              = 1'b1;
					res.kind          = KIND_CTRL;
					res.key_or_number = cd1;
					res.value         = 14'(cd2);
				end
				MSG_BEND: begin
					emit      = 1'b1;
					res.kind  = KIND_BEND;
					res.value = {cd2, cd1};
				end
				MSG_PROG: begin
					emit      = 1'b1;
					res.kind  = KIND_PROG;
					res.value = 14'(cd1);
				end
				MSG_PRESS: begin
					emit      = 1'b1;
					res.kind  = KIND_PRESS;
					res.value = 14'(cd1);
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end

		req.lookup    = s1_go && look;
		req.look_addr = {e_rs[3:0], b[6:0]};
		req.wr        = s1_go && (note_start || (note_end && rd_rec.sounding));
		req.wr_addr   = {ch, cd1};
		req.wr_rec    = note_start
			? note_rec_t'{sounding: 1'b1, velocity: cd2, start: 32'(e_tick)}
			: note_rec_t'{sounding: 1'b0, velocity: rd_rec.velocity, start: rd_rec.start};
		req.new_track = s1_go && tstart_s1;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1   <= data_byte;
			tstart_s1 <= track_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_DELTA;
			rs_q     <= '0;
			tick_q   <= '0;
			vl_q     <= '0;
			first_q  <= '0;
			mkind_q  <= '0;
			mleft_q  <= '0;
			tempo_q  <= '0;
			tcount_q <= '0;
			opened_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (s1_go) begin
				phase_q  <= n_phase;
				rs_q     <= n_rs;
				tick_q   <= n_tick;
				vl_q     <= n_vl;
				first_q  <= n_first;
				mkind_q  <= n_mkind;
				mleft_q  <= n_mleft;
				tempo_q  <= n_tempo;
				tcount_q <= e_tcount;
				opened_q <= opened_q || tstart_s1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/midi_track_event_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI track event parser
// Latency: a result passes through the input register, then the result register,
// after the byte that completes it is accepted.
// Throughput: one byte per cycle while in_stall is low; the note table takes at
// most one access per byte. Reset: asynchronous; afterwards in_stall stays high
// while the note table clearing pass writes every slot.
// ----------------------------------------------------------------------------
module midi_track_event_parser import mtep_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        track_start,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       kind,
	output logic [3:0]       channel,
	output logic [6:0]       key_or_number,
	output logic [13:0]      value,
	output logic [31:0]      start_tick,
	output logic [31:0]      event_tick,
	output logic [23:0]      tempo_usec,
	output logic [7:0]       track_number
);

	tbl_req_t  req;
	note_rec_t rd_rec;
	logic      busy;
	logic      out_free;
	logic      res_vld;
	res_t      res;
	logic      out_valid_q;
	res_t      res_q;

	assign out_free = !out_valid_q || !out_stall;

	mtep_note_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd_rec (rd_rec),
		.busy   (busy)
	);

	mtep_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.track_start (track_start),
		.busy        (busy),
		.out_free    (out_free),
		.rd_rec      (rd_rec),
		.req         (req),
		.res_vld     (res_vld),
		.res         (res)
	);

	// hold the transaction until taken
	always_ff @(posedge clk) begin
		if (out_free && res_vld) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_vld;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = res_q.kind;
	assign channel       = res_q.channel;
	assign key_or_number = res_q.key_or_number;
	assign value         = res_q.value;
	assign start_tick    = res_q.start_tick;
	assign event_tick    = res_q.event_tick;
	assign tempo_usec    = res_q.tempo_usec;
	assign track_number  = res_q.track_number;

endmodule
`default_nettype wire
